// ===== rtl/bitmap_block_allocator_defines.svh =====
// Assertion macros used by the bitmap block allocator top level.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BBA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bitmap_block_allocator: check failed");
`define BBA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("bitmap_block_allocator: check failed");
`else
`define BBA_ASSERT(name, prop)
`define BBA_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/bba_pkg.sv =====
// Shared constants, types and command codes of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = MAP_WORDS / GROUP_SIZE;

  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(MAP_WORDS);
  localparam int GRP_SEL_W = $clog2(GROUP_SIZE);
  localparam int GRP_W     = $clog2(GROUPS);
  localparam int STATUS_W  = 2;

  typedef logic [IDX_W-1:0]     blk_idx_t;
  typedef logic [CNT_W-1:0]     blk_cnt_t;
  typedef logic [BIT_W-1:0]     bit_sel_t;
  typedef logic [WADDR_W-1:0]   word_addr_t;
  typedef logic [GRP_SEL_W-1:0] grp_sel_t;
  typedef logic [GRP_W-1:0]     grp_t;
  typedef logic [WORD_BITS-1:0] map_word_t;
  typedef logic [STATUS_W-1:0]  status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_RANGE = 2'd2;

  localparam blk_cnt_t BLOCKS_RESET = CNT_W'(MAX_BLOCKS);

  // What the datapath does when a request finishes.
  typedef enum logic [1:0] {
    COMMIT_NONE,
    COMMIT_WORD,
    COMMIT_FULL,
    COMMIT_RANGE
  } commit_e;

  typedef struct packed {
    logic    capture;
    logic    scan_step;
    logic    read_word;
    commit_e commit;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic range_err;
    logic grp_hit;
    logic grp_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_defines.svh"

// First-fit block allocator over a 4096-bit used map held in 128 words of 32 bits.
// An allocate request runs a scan of up to 16 steps over per-word full flags, eight
// words a step, then one memory read and one update of the map word. A free request
// does one read and one write of the map word, and an out-of-range free does neither.
// One request is in progress at a time; a new one is accepted while the previous
// result still waits in the output register. The map is empty straight after reset,
// with no clearing pass. Block count writes are meant to arrive only while the block
// is idle.
module bitmap_block_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [15:0]                  s_axis_tdata,  // [11:0] block_index
  input  wire  [0:0]                   s_axis_tuser,  // [0] cmd
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // [11:0] alloc_index
  output logic [1:0]                   m_axis_tuser,  // [1:0] status
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [bba_pkg::CNT_W-1:0]    cfg_data_i     // total_blocks
);

  bba_pkg::blk_cnt_t total_blocks_q;
  bba_pkg::blk_cnt_t block_limit;
  bba_pkg::dp_cmd_t  dp_cmd;
  bba_pkg::dp_sts_t  dp_sts;
  bba_pkg::blk_idx_t out_idx;
  bba_pkg::status_t  out_status;
  bba_pkg::blk_cnt_t out_idx_ext;
  logic              out_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_blocks_q <= bba_pkg::BLOCKS_RESET;
    end else if (cfg_valid_i) begin
      total_blocks_q <= cfg_data_i;
    end
  end

  // Counts above the map capacity act as the full capacity.
  assign block_limit = (total_blocks_q > bba_pkg::BLOCKS_RESET) ? bba_pkg::BLOCKS_RESET
                                                                : total_blocks_q;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  bba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .req_cmd_i    (s_axis_tuser[0]),
    .req_idx_i    (s_axis_tdata[bba_pkg::IDX_W-1:0]),
    .limit_i      (block_limit),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_idx_o    (out_idx),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {{(16 - bba_pkg::IDX_W){1'b0}}, out_idx};
  assign m_axis_tuser = out_status;

  assign out_idx_ext = {1'b0, out_idx};
  assign out_ok      = (out_status == bba_pkg::STATUS_OK);

  // A successful result always names a block below the current block count.
  `BBA_ASSERT(a_ok_below_limit, m_axis_tvalid && out_ok |-> (out_idx_ext < block_limit))
  // Failed allocates and all frees return a zero index.
  `BBA_ASSERT(a_fail_zero_index, m_axis_tvalid && !out_ok |-> (out_idx == '0))
  // A request only finishes while no new one can be taken.
  `BBA_ASSERT(a_commit_busy, (dp_cmd.commit != bba_pkg::COMMIT_NONE) |-> !s_axis_tready)
  // After a request is taken the input stays closed for at least the next cycle.
  `BBA_ASSERT(a_capture_closes, dp_cmd.capture |=> !s_axis_tready)

endmodule

`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
// Controller state machine sequencing scan, read and update of each request.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_WAIT     = 3'd3;
  localparam logic [2:0] S_WRITE    = 3'd4;
  localparam logic [2:0] S_FULL     = 3'd5;
  localparam logic [2:0] S_RANGE    = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.capture   = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.read_word = 1'b0;
    cmd_o.commit    = bba_pkg::COMMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.req_free) begin
          if (sts_i.range_err) begin
            state_d = S_RANGE;
          end else begin
            cmd_o.read_word = 1'b1;
            state_d         = S_WAIT;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.grp_hit) begin
          cmd_o.read_word = 1'b1;
          state_d         = S_WAIT;
        end else if (sts_i.grp_last) begin
          state_d = S_FULL;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_WAIT: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = bba_pkg::COMMIT_WORD;
          state_d      = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.commit = bba_pkg::COMMIT_FULL;
          state_d      = S_IDLE;
        end
      end
      S_RANGE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = bba_pkg::COMMIT_RANGE;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bba_dp.sv =====
// Datapath: bitmap memory, word-full flags, search encoders and result register.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire bba_pkg::dp_cmd_t       cmd_i,
  output bba_pkg::dp_sts_t            sts_o,
  input  wire                         req_cmd_i,
  input  wire  [bba_pkg::IDX_W-1:0]   req_idx_i,
  input  wire  [bba_pkg::CNT_W-1:0]   limit_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output bba_pkg::blk_idx_t           out_idx_o,
  output bba_pkg::status_t            out_status_o
);

  // Bitmap store; a row never written since reset reads as all free.
  bba_pkg::map_word_t mem [bba_pkg::MAP_WORDS];

  logic [bba_pkg::MAP_WORDS-1:0] row_valid_q;
  logic [bba_pkg::MAP_WORDS-1:0] full_q;

  logic                  req_cmd_q;
  bba_pkg::blk_idx_t     req_idx_q;
  bba_pkg::grp_t         grp_q;
  bba_pkg::word_addr_t   word_q;
  bba_pkg::map_word_t    rd_data_q;
  logic                  rd_valid_q;
  logic                  out_valid_q;
  bba_pkg::blk_idx_t     out_idx_q;
  bba_pkg::status_t      out_status_q;

  logic [bba_pkg::GROUP_SIZE-1:0] grp_vec;
  logic                  grp_hit;
  bba_pkg::grp_sel_t     grp_pos;
  bba_pkg::word_addr_t   rd_addr;
  bba_pkg::map_word_t    cur_word;
  bba_pkg::bit_sel_t     bit_pos;
  bba_pkg::blk_idx_t     cand_idx;
  logic                  cand_ok;
  bba_pkg::map_word_t    one_word;
  logic                  wr_en;
  bba_pkg::map_word_t    wr_data;
  logic                  load_out;
  bba_pkg::blk_idx_t     res_idx;
  bba_pkg::status_t      res_status;
  logic                  out_free;

  // Word-full flags of the current group of eight words.
  assign grp_vec = full_q[{grp_q, {bba_pkg::GRP_SEL_W{1'b0}}} +: bba_pkg::GROUP_SIZE];
  assign grp_hit = ~&grp_vec;

  always_comb begin
    grp_pos = '0;
    for (int i = bba_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
      if (!grp_vec[i]) begin
        grp_pos = bba_pkg::grp_sel_t'(i);
      end
    end
  end

  assign rd_addr = (req_cmd_q == bba_pkg::CMD_FREE) ? req_idx_q[bba_pkg::IDX_W-1:bba_pkg::BIT_W]
                                                    : {grp_q, grp_pos};

  assign cur_word = rd_valid_q ? rd_data_q : '0;

  always_comb begin
    bit_pos = '0;
    for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!cur_word[i]) begin
        bit_pos = bba_pkg::bit_sel_t'(i);
      end
    end
  end

  assign cand_idx = {word_q, bit_pos};
  assign cand_ok  = {1'b0, cand_idx} < limit_i;
  assign one_word = {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    wr_en      = 1'b0;
    wr_data    = cur_word;
    load_out   = 1'b0;
    res_idx    = '0;
    res_status = bba_pkg::STATUS_OK;
    case (cmd_i.commit)
      bba_pkg::COMMIT_WORD: begin
        load_out = 1'b1;
        if (req_cmd_q == bba_pkg::CMD_FREE) begin
          wr_en   = 1'b1;
          wr_data = cur_word & ~(one_word << req_idx_q[bba_pkg::BIT_W-1:0]);
        end else if (cand_ok) begin
          wr_en   = 1'b1;
          wr_data = cur_word | (one_word << bit_pos);
          res_idx = cand_idx;
        end else begin
          // The first free bit lies at or above the block count.
          res_status = bba_pkg::STATUS_FULL;
        end
      end
      bba_pkg::COMMIT_FULL: begin
        load_out   = 1'b1;
        res_status = bba_pkg::STATUS_FULL;
      end
      bba_pkg::COMMIT_RANGE: begin
        load_out   = 1'b1;
        res_status = bba_pkg::STATUS_RANGE;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[word_q] <= wr_data;
    end
    if (cmd_i.read_word) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      full_q      <= '0;
      req_cmd_q   <= bba_pkg::CMD_ALLOC;
      req_idx_q   <= '0;
      grp_q       <= '0;
      word_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        req_cmd_q <= req_cmd_i;
        req_idx_q <= req_idx_i;
        grp_q     <= '0;
      end else if (cmd_i.scan_step) begin
        grp_q <= grp_q + 1'b1;
      end
      if (cmd_i.read_word) begin
        word_q     <= rd_addr;
        rd_valid_q <= row_valid_q[rd_addr];
      end
      if (wr_en) begin
        row_valid_q[word_q] <= 1'b1;
        full_q[word_q]      <= (req_cmd_q == bba_pkg::CMD_FREE) ? 1'b0 : &wr_data;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q    <= res_idx;
      out_status_q <= res_status;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.req_free  = (req_cmd_q == bba_pkg::CMD_FREE);
  assign sts_o.range_err = {1'b0, req_idx_q} >= limit_i;
  assign sts_o.grp_hit   = grp_hit;
  assign sts_o.grp_last  = (grp_q == bba_pkg::grp_t'(bba_pkg::GROUPS - 1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_idx_o    = out_idx_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire
